/* rtl/rus_pkg.sv */
// Shared types and constants for the rectangle union splitter.
// Used by rus_pipe and rect_union_disjoint_split_unit; depends on nothing.
package rus_pkg;

  localparam int NSLOT = 5;

  // Fixed slot order of the pieces of one transaction group.
  localparam int SLOT_OTHER = 0;
  localparam int SLOT_LEFT  = 1;
  localparam int SLOT_RIGHT = 2;
  localparam int SLOT_ABOVE = 3;
  localparam int SLOT_BELOW = 4;

  typedef logic [NSLOT-1:0] slot_mask_t;

  // Per-item control that travels with the piece slots.
  typedef struct packed {
    logic       overlap;
    slot_mask_t keep;
  } rus_ctl_t;

endpackage

/* rtl/rus_pipe.sv */
// Four-stage geometry pipeline: edges, tests and base choice, strip extents, piece slots.
// Depends on rus_pkg.
module rus_pipe import rus_pkg::*; #(
  parameter int COORD_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic        [COORD_BITS-2:0] a_w,
  input  logic        [COORD_BITS-2:0] a_h,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  input  logic        [COORD_BITS-2:0] b_w,
  input  logic        [COORD_BITS-2:0] b_h,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output rus_ctl_t                     dn_ctl,
  output logic signed [COORD_BITS:0]   dn_x [NSLOT],
  output logic signed [COORD_BITS:0]   dn_y [NSLOT],
  output logic        [COORD_BITS-1:0] dn_w [NSLOT],
  output logic        [COORD_BITS-1:0] dn_h [NSLOT]
);

  localparam int CB = COORD_BITS;
  localparam int SW = COORD_BITS - 1;
  localparam int PW = COORD_BITS + 1;
  localparam int LW = COORD_BITS;
  localparam int EW = COORD_BITS + 2;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4 = !v4 || dn_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign up_ready = en1;
  assign dn_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= up_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Stage 1: inputs and exclusive right and bottom edges.
  logic signed [CB-1:0] s1_ax, s1_ay, s1_bx, s1_by;
  logic        [SW-1:0] s1_aw, s1_ah, s1_bw, s1_bh;
  logic signed [PW-1:0] s1_ar, s1_ab, s1_br, s1_bb;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ax <= a_x;
      s1_ay <= a_y;
      s1_aw <= a_w;
      s1_ah <= a_h;
      s1_bx <= b_x;
      s1_by <= b_y;
      s1_bw <= b_w;
      s1_bh <= b_h;
      s1_ar <= PW'(a_x) + PW'($signed({1'b0, a_w}));
      s1_ab <= PW'(a_y) + PW'($signed({1'b0, a_h}));
      s1_br <= PW'(b_x) + PW'($signed({1'b0, b_w}));
      s1_bb <= PW'(b_y) + PW'($signed({1'b0, b_h}));
    end
  end

  // Stage 2: overlap, equality and containment tests; pick base and other.
  logic ovl_c, same_c, encl_c;
  logic                 s2_ovl, s2_same;
  logic signed [CB-1:0] s2_bx, s2_by, s2_ox, s2_oy;
  logic        [SW-1:0] s2_bh, s2_ow, s2_oh;
  logic signed [PW-1:0] s2_br, s2_bb, s2_or, s2_ob;

  assign ovl_c  = (s1_ar > PW'(s1_bx)) && (s1_ab > PW'(s1_by)) &&
                  (s1_br > PW'(s1_ax)) && (s1_bb > PW'(s1_ay));
  assign same_c = (s1_ax == s1_bx) && (s1_ay == s1_by) &&
                  (s1_aw == s1_bw) && (s1_ah == s1_bh);
  assign encl_c = (s1_ax >= s1_bx) && (s1_ay >= s1_by) &&
                  (s1_ar <= s1_br) && (s1_ab <= s1_bb);

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_ovl  <= ovl_c;
      s2_same <= same_c;
      if (encl_c) begin
        s2_bx <= s1_bx; s2_by <= s1_by; s2_bh <= s1_bh;
        s2_br <= s1_br; s2_bb <= s1_bb;
        s2_ox <= s1_ax; s2_oy <= s1_ay; s2_ow <= s1_aw; s2_oh <= s1_ah;
        s2_or <= s1_ar; s2_ob <= s1_ab;
      end else begin
        s2_bx <= s1_ax; s2_by <= s1_ay; s2_bh <= s1_ah;
        s2_br <= s1_ar; s2_bb <= s1_ab;
        s2_ox <= s1_bx; s2_oy <= s1_by; s2_ow <= s1_bw; s2_oh <= s1_bh;
        s2_or <= s1_br; s2_ob <= s1_bb;
      end
    end
  end

  // Stage 3: strip extents of the base around the other rectangle.
  logic                 s3_ovl, s3_same;
  logic signed [CB-1:0] s3_bx, s3_by, s3_ox, s3_oy;
  logic        [SW-1:0] s3_bh, s3_ow, s3_oh;
  logic signed [PW-1:0] s3_br, s3_or, s3_ob;
  logic signed [PW-1:0] s3_lw, s3_th;
  logic signed [EW-1:0] s3_rw, s3_bhs;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_ovl  <= s2_ovl;
      s3_same <= s2_same;
      s3_bx   <= s2_bx;
      s3_by   <= s2_by;
      s3_bh   <= s2_bh;
      s3_br   <= s2_br;
      s3_ox   <= s2_ox;
      s3_oy   <= s2_oy;
      s3_ow   <= s2_ow;
      s3_oh   <= s2_oh;
      s3_or   <= s2_or;
      s3_ob   <= s2_ob;
      s3_lw   <= PW'(s2_ox) - PW'(s2_bx);
      s3_th   <= PW'(s2_oy) - PW'(s2_by);
      s3_rw   <= EW'(s2_br) - EW'(s2_or);
      s3_bhs  <= EW'(s2_bb) - EW'(s2_ob);
    end
  end

  // Stage 4: presence of each strip and the clipped span of above and below.
  logic                 lp, rp, tp, bp;
  logic signed [CB-1:0] hx;
  logic signed [PW-1:0] right_end;
  logic signed [EW-1:0] hw_full;
  logic        [LW-1:0] hw;

  assign lp = !s3_lw[PW-1]  && (s3_lw  != '0);
  assign rp = !s3_rw[EW-1]  && (s3_rw  != '0);
  assign tp = !s3_th[PW-1]  && (s3_th  != '0);
  assign bp = !s3_bhs[EW-1] && (s3_bhs != '0);
  assign hx        = lp ? s3_ox : s3_bx;
  assign right_end = rp ? s3_or : s3_br;
  assign hw_full   = EW'(right_end) - EW'(hx);
  assign hw        = hw_full[LW-1:0];

  always_ff @(posedge clk) begin
    if (en4) begin
      dn_ctl.overlap <= s3_ovl;
      if (s3_ovl && !s3_same) begin
        dn_ctl.keep <= {bp, tp, rp, lp, 1'b1};
      end else begin
        dn_ctl.keep <= slot_mask_t'(1);
      end
      if (s3_ovl) begin
        dn_x[SLOT_OTHER] <= PW'(s3_ox);
        dn_y[SLOT_OTHER] <= PW'(s3_oy);
        dn_w[SLOT_OTHER] <= LW'(s3_ow);
        dn_h[SLOT_OTHER] <= LW'(s3_oh);
      end else begin
        dn_x[SLOT_OTHER] <= '0;
        dn_y[SLOT_OTHER] <= '0;
        dn_w[SLOT_OTHER] <= '0;
        dn_h[SLOT_OTHER] <= '0;
      end
      dn_x[SLOT_LEFT]  <= PW'(s3_bx);
      dn_y[SLOT_LEFT]  <= PW'(s3_by);
      dn_w[SLOT_LEFT]  <= s3_lw[LW-1:0];
      dn_h[SLOT_LEFT]  <= LW'(s3_bh);
      dn_x[SLOT_RIGHT] <= s3_or;
      dn_y[SLOT_RIGHT] <= PW'(s3_by);
      dn_w[SLOT_RIGHT] <= s3_rw[LW-1:0];
      dn_h[SLOT_RIGHT] <= LW'(s3_bh);
      dn_x[SLOT_ABOVE] <= PW'(hx);
      dn_y[SLOT_ABOVE] <= PW'(s3_by);
      dn_w[SLOT_ABOVE] <= hw;
      dn_h[SLOT_ABOVE] <= s3_th[LW-1:0];
      dn_x[SLOT_BELOW] <= PW'(hx);
      dn_y[SLOT_BELOW] <= s3_ob;
      dn_w[SLOT_BELOW] <= hw;
      dn_h[SLOT_BELOW] <= s3_bhs[LW-1:0];
    end
  end

endmodule

/* rtl/rect_union_disjoint_split_unit.sv */
// Top level of the rectangle union splitter: geometry pipeline plus result sequencer.
// Depends on rus_pkg and rus_pipe.
//
// This block takes two rectangles per input transaction and returns the union of
// them as non-overlapping pieces, one output transaction per piece, the final one
// flagged by last. Non-overlapping inputs give one transaction with overlap low and
// zero geometry; identical inputs give the first rectangle alone. Otherwise the
// other rectangle comes first, then the left, right, above and below strips of
// the base rectangle that are present. An input transaction can be accepted on
// every clock while the pipeline is not stalled: it runs through a four-stage
// pipeline (edge sums, overlap and containment tests, strip extents, piece slots)
// and then lands in a result register, where the first result is visible. Each
// input yields one to five results and the result register sends one per cycle
// while out_ready is high, so an input holds the register until its final piece
// is taken; the pipeline keeps accepting while pieces drain until its stages fill,
// and back-pressure on the result side stalls it without loss.
module rect_union_disjoint_split_unit import rus_pkg::*; #(
  parameter int COORD_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic        [COORD_BITS-2:0] a_w,
  input  logic        [COORD_BITS-2:0] a_h,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  input  logic        [COORD_BITS-2:0] b_w,
  input  logic        [COORD_BITS-2:0] b_h,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         overlap,
  output logic signed [COORD_BITS:0]   piece_x,
  output logic signed [COORD_BITS:0]   piece_y,
  output logic        [COORD_BITS-1:0] piece_w,
  output logic        [COORD_BITS-1:0] piece_h,
  output logic                         last
);

  localparam int PW = COORD_BITS + 1;
  localparam int LW = COORD_BITS;

  logic                 pipe_valid;
  logic                 pipe_ready;
  rus_ctl_t             pipe_ctl;
  logic signed [PW-1:0] pipe_x [NSLOT];
  logic signed [PW-1:0] pipe_y [NSLOT];
  logic        [LW-1:0] pipe_w [NSLOT];
  logic        [LW-1:0] pipe_h [NSLOT];

  rus_pipe #(
    .COORD_BITS(COORD_BITS)
  ) u_pipe (
    .clk     (clk),
    .rst     (rst),
    .up_valid(in_valid),
    .up_ready(in_ready),
    .a_x     (a_x),
    .a_y     (a_y),
    .a_w     (a_w),
    .a_h     (a_h),
    .b_x     (b_x),
    .b_y     (b_y),
    .b_w     (b_w),
    .b_h     (b_h),
    .dn_valid(pipe_valid),
    .dn_ready(pipe_ready),
    .dn_ctl  (pipe_ctl),
    .dn_x    (pipe_x),
    .dn_y    (pipe_y),
    .dn_w    (pipe_w),
    .dn_h    (pipe_h)
  );

  // Result register: holds all slots of one item and a mask of the pieces still
  // to be sent. The lowest set bit of the mask picks the piece on the port.
  logic                 hold_v;
  logic                 hold_ovl;
  slot_mask_t           rem;
  slot_mask_t           rem_next;
  slot_mask_t           sel;
  logic signed [PW-1:0] hold_x [NSLOT];
  logic signed [PW-1:0] hold_y [NSLOT];
  logic        [LW-1:0] hold_w [NSLOT];
  logic        [LW-1:0] hold_h [NSLOT];
  logic                 out_fire;
  logic                 load;

  assign rem_next   = rem & (rem - slot_mask_t'(1));
  assign sel        = rem & ~rem_next;
  assign out_valid  = hold_v;
  assign last       = (rem_next == '0);
  assign overlap    = hold_ovl;
  assign out_fire   = out_valid && out_ready;
  // A new item may enter when the register is empty or its final piece leaves now.
  assign pipe_ready = !hold_v || (out_fire && last);
  assign load       = pipe_valid && pipe_ready;

  always_comb begin
    piece_x = '0;
    piece_y = '0;
    piece_w = '0;
    piece_h = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (sel[i]) begin
        piece_x = piece_x | hold_x[i];
        piece_y = piece_y | hold_y[i];
        piece_w = piece_w | hold_w[i];
        piece_h = piece_h | hold_h[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      rem    <= '0;
    end else if (load) begin
      hold_v <= 1'b1;
      rem    <= pipe_ctl.keep;
    end else if (out_fire) begin
      hold_v <= !last;
      rem    <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_ovl <= pipe_ctl.overlap;
      hold_x   <= pipe_x;
      hold_y   <= pipe_y;
      hold_w   <= pipe_w;
      hold_h   <= pipe_h;
    end
  end

`ifndef SYNTHESIS
  // A held item always has at least one piece left to send.
  a_rem_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rem != '0))
    else $error("result register valid with no pieces left");

  // A non-overlap result is a single transaction with zero geometry.
  a_no_ovl_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !overlap) |-> (last && piece_w == '0 && piece_h == '0 &&
                                 piece_x == '0 && piece_y == '0))
    else $error("non-overlap result is not a single zero piece");

  // After a non-final piece is taken, the next piece of the item is presented.
  a_continue: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !last) |=> (out_valid && $stable(hold_ovl)))
    else $error("pieces of one item were cut short");

  // The first piece of an item is never dropped from the mask before it is sent.
  a_first_piece: assert property (@(posedge clk) disable iff (rst)
    load |=> rem[SLOT_OTHER])
    else $error("first piece missing from a newly loaded item");
`endif

endmodule
